/* design/orf_pkg.sv */
// Shared types and constants for the orbit representative finder.
`timescale 1ns / 1ps

package orf_pkg;

    localparam int STATE_W   = 64;
    localparam int SYM_W     = 6;
    localparam int SITE_W    = 6;
    localparam int CNT_W     = 7;
    localparam int MAX_SITES = 64;
    localparam int MAX_SYMS  = 64;
    localparam int TBL_AW    = SYM_W + SITE_W;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [0:0] REG_SITE_COUNT = 1'b0;
    localparam logic [0:0] REG_SYM_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELECT,
        ST_SCAN,
        ST_DRAIN,
        ST_EVAL,
        ST_FINISH
    } t_state;

endpackage

/* design/orf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module orf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/orbit_representative_finder.sv */
// Top level of the orbit representative finder: table load, query sequencer and result register.
`timescale 1ns / 1ps

// The input channel carries one beat per item. A load beat (operation = 0) writes one
// permutation entry, the destination site of source site_index under symmetry sym_index,
// and produces no result beat. A query beat (operation = 1) permutes state_bits under
// every enabled symmetry below symmetry_count and produces exactly one result beat.
// The block takes a new beat only while its sequencer is idle. A query walks the
// symmetries one per step: a disabled symmetry only passes SELECT, an enabled one passes
// SELECT, SCAN once per site, DRAIN and EVAL (only SELECT and EVAL with a site count of 0),
// because the table memory delivers one 6-bit entry per cycle and every site is moved
// through one shared bit-placement unit.
// Results sit in an output register. When the receiver stalls, the block still accepts
// the next beat; a query that finishes while the register is still full waits in its
// final state until the held result beat is taken.
// Reset returns site_count to 64 and symmetry_count to 0 and empties the result register.
// The permutation table is not cleared: every entry that a query reads must be loaded first.
// The APB port holds site_count at address 0 and symmetry_count at address 4; both read back.

module orbit_representative_finder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_operation,
    input  logic [orf_pkg::SYM_W-1:0]     i_sym_index,
    input  logic [orf_pkg::SITE_W-1:0]    i_site_index,
    input  logic [orf_pkg::SITE_W-1:0]    i_dest_site,
    input  logic [orf_pkg::STATE_W-1:0]   i_state_bits,
    input  logic [orf_pkg::STATE_W-1:0]   i_target_bits,
    input  logic [orf_pkg::MAX_SYMS-1:0]  i_sym_enable,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [orf_pkg::STATE_W-1:0]   o_representative,
    output logic [orf_pkg::SYM_W-1:0]     o_rep_symmetry,
    output logic [orf_pkg::MAX_SYMS-1:0]  o_rep_mask,
    output logic [orf_pkg::MAX_SYMS-1:0]  o_stabilizer_mask,
    output logic [orf_pkg::MAX_SYMS-1:0]  o_mapping_mask
);

    // Configuration registers.
    logic [orf_pkg::CNT_W-1:0] r_site_count;
    logic [orf_pkg::CNT_W-1:0] r_sym_count;
    logic                      w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_site_count <= orf_pkg::CNT_W'(orf_pkg::MAX_SITES);
            r_sym_count  <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                orf_pkg::REG_SITE_COUNT: r_site_count <= pwdata[orf_pkg::CNT_W-1:0];
                orf_pkg::REG_SYM_COUNT:  r_sym_count  <= pwdata[orf_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            orf_pkg::REG_SITE_COUNT: prdata = {{(32 - orf_pkg::CNT_W){1'b0}}, r_site_count};
            orf_pkg::REG_SYM_COUNT:  prdata = {{(32 - orf_pkg::CNT_W){1'b0}}, r_sym_count};
            default:                 prdata = '0;
        endcase
    end

    // Sequencer state and query context.
    orf_pkg::t_state r_state, n_state;

    logic [orf_pkg::STATE_W-1:0]  r_st, n_st;
    logic [orf_pkg::STATE_W-1:0]  r_tg, n_tg;
    logic [orf_pkg::MAX_SYMS-1:0] r_en, n_en;
    logic [orf_pkg::CNT_W-1:0]    r_sites, n_sites;
    logic [orf_pkg::CNT_W-1:0]    r_nsym, n_nsym;
    logic [orf_pkg::CNT_W-1:0]    r_sym, n_sym;
    logic [orf_pkg::CNT_W-1:0]    r_site, n_site;
    logic [orf_pkg::SITE_W-1:0]   r_rd_site, n_rd_site;
    logic                         r_rd_vld, n_rd_vld;
    logic [orf_pkg::STATE_W-1:0]  r_img, n_img;
    logic [orf_pkg::STATE_W-1:0]  r_rep, n_rep;
    logic [orf_pkg::SYM_W-1:0]    r_rep_sym, n_rep_sym;
    logic [orf_pkg::MAX_SYMS-1:0] r_rep_mask, n_rep_mask;
    logic [orf_pkg::MAX_SYMS-1:0] r_stab, n_stab;
    logic [orf_pkg::MAX_SYMS-1:0] r_map, n_map;
    logic                         r_any, n_any;

    // Result register.
    logic                         r_out_valid, n_out_valid;
    logic [orf_pkg::STATE_W-1:0]  r_out_rep, n_out_rep;
    logic [orf_pkg::SYM_W-1:0]    r_out_sym, n_out_sym;
    logic [orf_pkg::MAX_SYMS-1:0] r_out_rmask, n_out_rmask;
    logic [orf_pkg::MAX_SYMS-1:0] r_out_smask, n_out_smask;
    logic [orf_pkg::MAX_SYMS-1:0] r_out_mmask, n_out_mmask;

    // Table memory signals.
    logic                         w_tbl_wr;
    logic                         w_tbl_rd;
    logic [orf_pkg::TBL_AW-1:0]   w_tbl_wr_addr;
    logic [orf_pkg::TBL_AW-1:0]   w_tbl_rd_addr;
    logic [orf_pkg::SITE_W-1:0]   w_tbl_rd_data;

    logic                         w_in_acc;
    logic [orf_pkg::STATE_W-1:0]  w_place;
    logic [orf_pkg::MAX_SYMS-1:0] w_sym_bit;

    assign o_in_ready    = (r_state == orf_pkg::ST_IDLE);
    assign w_in_acc      = i_in_valid && o_in_ready;
    assign w_tbl_wr      = w_in_acc && (i_operation == orf_pkg::OP_LOAD);
    assign w_tbl_wr_addr = {i_sym_index, i_site_index};
    assign w_tbl_rd      = (r_state == orf_pkg::ST_SCAN);
    assign w_tbl_rd_addr = {r_sym[orf_pkg::SYM_W-1:0], r_site[orf_pkg::SITE_W-1:0]};
    assign w_sym_bit     = orf_pkg::MAX_SYMS'(1) << r_sym[orf_pkg::SYM_W-1:0];

    orf_ram #(
        .WIDTH (orf_pkg::SITE_W),
        .DEPTH (orf_pkg::TBL_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_tbl_wr),
        .i_wr_addr (w_tbl_wr_addr),
        .i_wr_data (i_dest_site),
        .i_rd_en   (w_tbl_rd),
        .i_rd_addr (w_tbl_rd_addr),
        .o_rd_data (w_tbl_rd_data)
    );

    // Shared bit-placement unit: the state bit of the site read last cycle lands at the
    // destination that the table returned.
    always_comb begin
        w_place                = '0;
        w_place[w_tbl_rd_data] = r_st[r_rd_site];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= orf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_vld    <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_st        <= n_st;
        r_tg        <= n_tg;
        r_en        <= n_en;
        r_sites     <= n_sites;
        r_nsym      <= n_nsym;
        r_sym       <= n_sym;
        r_site      <= n_site;
        r_rd_site   <= n_rd_site;
        r_img       <= n_img;
        r_rep       <= n_rep;
        r_rep_sym   <= n_rep_sym;
        r_rep_mask  <= n_rep_mask;
        r_stab      <= n_stab;
        r_map       <= n_map;
        r_any       <= n_any;
        r_out_rep   <= n_out_rep;
        r_out_sym   <= n_out_sym;
        r_out_rmask <= n_out_rmask;
        r_out_smask <= n_out_smask;
        r_out_mmask <= n_out_mmask;
    end

    always_comb begin
        n_state     = r_state;
        n_st        = r_st;
        n_tg        = r_tg;
        n_en        = r_en;
        n_sites     = r_sites;
        n_nsym      = r_nsym;
        n_sym       = r_sym;
        n_site      = r_site;
        n_rd_site   = r_rd_site;
        n_rd_vld    = 1'b0;
        n_img       = r_img;
        n_rep       = r_rep;
        n_rep_sym   = r_rep_sym;
        n_rep_mask  = r_rep_mask;
        n_stab      = r_stab;
        n_map       = r_map;
        n_any       = r_any;
        n_out_valid = r_out_valid;
        n_out_rep   = r_out_rep;
        n_out_sym   = r_out_sym;
        n_out_rmask = r_out_rmask;
        n_out_smask = r_out_smask;
        n_out_mmask = r_out_mmask;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // A table entry read in the previous cycle is folded into the image.
        if (r_rd_vld) begin
            n_img = r_img | w_place;
        end

        case (r_state)
            orf_pkg::ST_IDLE: begin
                if (w_in_acc && (i_operation == orf_pkg::OP_QUERY)) begin
                    n_st       = i_state_bits;
                    n_tg       = i_target_bits;
                    n_en       = i_sym_enable;
                    n_sites    = (r_site_count > orf_pkg::CNT_W'(orf_pkg::MAX_SITES)) ?
                                 orf_pkg::CNT_W'(orf_pkg::MAX_SITES) : r_site_count;
                    n_nsym     = (r_sym_count > orf_pkg::CNT_W'(orf_pkg::MAX_SYMS)) ?
                                 orf_pkg::CNT_W'(orf_pkg::MAX_SYMS) : r_sym_count;
                    n_sym      = '0;
                    n_rep      = '1;
                    n_rep_sym  = '0;
                    n_rep_mask = '0;
                    n_stab     = '0;
                    n_map      = '0;
                    n_any      = 1'b0;
                    n_state    = orf_pkg::ST_SELECT;
                end
            end
            orf_pkg::ST_SELECT: begin
                if (r_sym == r_nsym) begin
                    n_state = orf_pkg::ST_FINISH;
                end else if (r_en[r_sym[orf_pkg::SYM_W-1:0]]) begin
                    n_site = '0;
                    n_img  = '0;
                    // With no sites every image is zero and no entry is read.
                    n_state = (r_sites == '0) ? orf_pkg::ST_EVAL : orf_pkg::ST_SCAN;
                end else begin
                    n_sym = r_sym + 1'b1;
                end
            end
            orf_pkg::ST_SCAN: begin
                n_rd_vld  = 1'b1;
                n_rd_site = r_site[orf_pkg::SITE_W-1:0];
                n_site    = r_site + 1'b1;
                if (r_site == r_sites - 1'b1) begin
                    n_state = orf_pkg::ST_DRAIN;
                end
            end
            orf_pkg::ST_DRAIN: begin
                n_state = orf_pkg::ST_EVAL;
            end
            orf_pkg::ST_EVAL: begin
                n_any = 1'b1;
                if (r_img < r_rep) begin
                    n_rep      = r_img;
                    n_rep_sym  = r_sym[orf_pkg::SYM_W-1:0];
                    n_rep_mask = w_sym_bit;
                end else if (r_img == r_rep) begin
                    n_rep_mask = r_rep_mask | w_sym_bit;
                end
                if (r_img == r_st) begin
                    n_stab = r_stab | w_sym_bit;
                end
                if (r_img == r_tg) begin
                    n_map = r_map | w_sym_bit;
                end
                n_sym   = r_sym + 1'b1;
                n_state = orf_pkg::ST_SELECT;
            end
            orf_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_rep   = r_any ? r_rep : r_st;
                    n_out_sym   = r_any ? r_rep_sym : '0;
                    n_out_rmask = r_rep_mask;
                    n_out_smask = r_stab;
                    n_out_mmask = r_map;
                    n_state     = orf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = orf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_representative  = r_out_rep;
    assign o_rep_symmetry    = r_out_sym;
    assign o_rep_mask        = r_out_rmask;
    assign o_stabilizer_mask = r_out_smask;
    assign o_mapping_mask    = r_out_mmask;

endmodule
